// ----- src/dcps_pkg.sv -----
`default_nettype none

package dcps_pkg;

    localparam int COUNTS_PER_RADIAN_DEF = 41;
    localparam int SPEED_DIVISOR_DEF     = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int FRAC_W      = 16;
    localparam int GAIN_FRAC_W = 24;
    localparam int SUM_W       = 48;
    localparam int DIVIDEND_W  = SUM_W + FRAC_W;
    localparam int PWM_W       = 14;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_POSITION_TOLERANCE  = 3'd0,
        CFG_DRIVE_LIMIT         = 3'd1,
        CFG_POSITION_GAIN       = 3'd2,
        CFG_ERROR_GAIN          = 3'd3,
        CFG_PREVIOUS_ERROR_GAIN = 3'd4,
        CFG_PWM_CENTER          = 3'd5,
        CFG_PWM_SLOPE           = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [30:0] position_tolerance;
        logic [30:0] drive_limit;
        logic [31:0] position_gain;
        logic [31:0] error_gain;
        logic [31:0] previous_error_gain;
        logic [13:0] pwm_center;
        logic [11:0] pwm_slope;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        position_tolerance:  31'd6554,
        drive_limit:         31'd786432,
        position_gain:       32'd23051993,
        error_gain:          32'd33554,
        previous_error_gain: 32'd83886,
        pwm_center:          14'd4200,
        pwm_slope:           12'd341
    };

    typedef struct packed {
        logic signed [15:0] left_count_delta;
        logic signed [15:0] right_count_delta;
        logic signed [15:0] left_target;
        logic signed [15:0] right_target;
        logic               clear_position;
    } tick_t;

    typedef struct packed {
        logic [PWM_W-1:0]   left_pwm;
        logic [PWM_W-1:0]   right_pwm;
        logic               left_enable;
        logic               right_enable;
        logic signed [31:0] left_drive;
        logic signed [31:0] right_drive;
        logic signed [31:0] left_angle;
        logic signed [31:0] right_angle;
    } result_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_ACC,
        OP_DIV_ANGLE,
        OP_ANGLE,
        OP_DIV_SPEED,
        OP_SPEED,
        OP_MUL_PGAIN,
        OP_STARGET,
        OP_SERR,
        OP_MUL_EGAIN,
        OP_MUL_PEGAIN,
        OP_SUM,
        OP_CLAMP,
        OP_MUL_SLOPE,
        OP_PWM,
        OP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   motor;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_full;
    } status_t;

    function automatic logic signed [31:0] sat_s32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (v < -66'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        else
        begin
            return v[31:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/dcps_divider.sv -----
`default_nettype none

module dcps_divider #(
    parameter int DIV_W = 6
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [dcps_pkg::DIVIDEND_W-1:0] dividend,
    input  wire logic [DIV_W-1:0]                divisor,
    output logic                                 busy,
    output logic [dcps_pkg::DIVIDEND_W-1:0]      quotient
);
    import dcps_pkg::*;

    localparam int STEPS  = 8;
    localparam int CYCLES = DIVIDEND_W / STEPS;
    localparam int CNT_W  = $clog2(CYCLES);

    logic                  busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] shift_reg, shift_next;
    logic [DIV_W-1:0]      divisor_reg;
    logic [DIV_W:0]        trial;

    // eight restoring steps per cycle on the narrow remainder
    always_comb
    begin
        rem_next   = rem_reg;
        shift_next = shift_reg;
        trial      = '0;
        for (int i = 0; i < STEPS; i++)
        begin
            trial      = {rem_next, shift_next[DIVIDEND_W-1]};
            shift_next = {shift_next[DIVIDEND_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_next      = DIV_W'(trial - {1'b0, divisor_reg});
                shift_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(CYCLES - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            shift_reg   <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg   <= rem_next;
            shift_reg <= shift_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = shift_reg;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
`endif

endmodule

`default_nettype wire

// ----- src/dcps_datapath.sv -----
`default_nettype none

module dcps_datapath #(
    parameter int COUNTS_PER_RADIAN = dcps_pkg::COUNTS_PER_RADIAN_DEF,
    parameter int SPEED_DIVISOR     = dcps_pkg::SPEED_DIVISOR_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dcps_pkg::cmd_t    cmd,
    output dcps_pkg::status_t      status,
    input  wire dcps_pkg::tick_t   tick,
    input  wire dcps_pkg::cfg_t    cfg,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output dcps_pkg::result_t      result
);
    import dcps_pkg::*;

    localparam int DIV_MAX = (COUNTS_PER_RADIAN > SPEED_DIVISOR) ? COUNTS_PER_RADIAN
                                                                 : SPEED_DIVISOR;
    localparam int DIV_W   = $clog2(DIV_MAX + 1);
    localparam int PROD_W  = 65;
    localparam int PHI_W   = PROD_W - GAIN_FRAC_W;
    localparam int TOTAL_W = PHI_W + 2;
    localparam int PQ_W    = 46;
    localparam int PQH_W   = PQ_W - FRAC_W;

    // per motor state
    logic signed [SUM_W-1:0] sum_reg        [2];
    logic signed [31:0]      last_serr_reg  [2];
    logic signed [31:0]      last_drive_reg [2];

    tick_t                   item_reg;
    logic signed [31:0]      perr_reg, speed_reg, starget_reg, serr_reg, drive_reg;
    logic signed [PHI_W-1:0] eterm_reg;
    logic signed [TOTAL_W-1:0] total_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    result_t                 res_reg, out_reg;
    logic                    out_valid_reg;

    logic                    sel;
    logic signed [15:0]      delta_sel, target_sel;
    logic signed [SUM_W-1:0] sum_cur, sum_sat;
    logic signed [SUM_W:0]   sum_add;
    logic [SUM_W-1:0]        sum_mag;
    logic [15:0]             delta_mag;

    logic                    div_start, div_busy;
    logic [DIVIDEND_W-1:0]   div_dividend, quotient;
    logic [DIV_W-1:0]        div_divisor;
    logic                    q_big;

    logic signed [31:0]      angle_val, speed_val, tgt_q, perr_val;
    logic signed [31:0]      starget_val, serr_val, drive_val;
    logic signed [32:0]      tol33, perr33;
    logic                    enable_val;
    logic signed [32:0]      mul_a;
    logic signed [31:0]      mul_b;
    logic                    mul_en;
    logic signed [PHI_W-1:0] prod_hi;
    logic signed [TOTAL_W-1:0] total_val, lim_t;
    logic signed [PQ_W-1:0]  center_q, pq;
    logic signed [PQH_W-1:0] pq_hi;
    logic [PWM_W-1:0]        pwm_val;
    logic signed [32:0]      lim33, drive33;

    assign sel        = cmd.motor;
    assign delta_sel  = sel ? item_reg.right_count_delta : item_reg.left_count_delta;
    assign target_sel = sel ? item_reg.right_target : item_reg.left_target;
    assign sum_cur    = sum_reg[sel];

    // count sum with 48-bit saturation
    assign sum_add = (SUM_W+1)'(sum_cur) + (SUM_W+1)'(delta_sel);
    assign sum_sat = (sum_add[SUM_W] != sum_add[SUM_W-1])
                   ? (sum_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}})
                   : sum_add[SUM_W-1:0];

    assign sum_mag   = sum_cur[SUM_W-1] ? SUM_W'(-sum_cur) : SUM_W'(sum_cur);
    assign delta_mag = delta_sel[15] ? 16'(-delta_sel) : 16'(delta_sel);

    assign div_start    = (cmd.op == OP_DIV_ANGLE) || (cmd.op == OP_DIV_SPEED);
    assign div_dividend = (cmd.op == OP_DIV_SPEED)
                        ? DIVIDEND_W'({delta_mag, {FRAC_W{1'b0}}})
                        : {sum_mag, {FRAC_W{1'b0}}};
    assign div_divisor  = (cmd.op == OP_DIV_SPEED) ? DIV_W'(SPEED_DIVISOR)
                                                   : DIV_W'(COUNTS_PER_RADIAN);

    dcps_divider #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // truncation toward zero: divide magnitudes, then restore the sign
    assign q_big = |quotient[DIVIDEND_W-1:31];

    always_comb
    begin
        if (q_big)
        begin
            angle_val = sum_cur[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            angle_val = sum_cur[SUM_W-1] ? -quotient[31:0] : quotient[31:0];
        end
    end

    assign speed_val = delta_sel[15] ? -quotient[31:0] : quotient[31:0];
    assign tgt_q     = {target_sel, {FRAC_W{1'b0}}};
    assign perr_val  = sat_s32(66'(tgt_q) - 66'(angle_val));

    assign tol33      = {2'b00, cfg.position_tolerance};
    assign perr33     = 33'(perr_reg);
    assign enable_val = !((perr33 < tol33) && (perr33 > -tol33));

    // shared multiplier operand select
    always_comb
    begin
        mul_en = 1'b1;
        case (cmd.op)
            OP_MUL_PGAIN:
            begin
                mul_a = {1'b0, cfg.position_gain};
                mul_b = perr_reg;
            end
            OP_MUL_EGAIN:
            begin
                mul_a = {1'b0, cfg.error_gain};
                mul_b = serr_reg;
            end
            OP_MUL_PEGAIN:
            begin
                mul_a = {1'b0, cfg.previous_error_gain};
                mul_b = last_serr_reg[sel];
            end
            OP_MUL_SLOPE:
            begin
                mul_a = {21'd0, cfg.pwm_slope};
                mul_b = drive_reg;
            end
            default:
            begin
                mul_en = 1'b0;
                mul_a  = '0;
                mul_b  = '0;
            end
        endcase
    end

    // floor of the product with a q8.24 gain
    assign prod_hi     = prod_reg[PROD_W-1:GAIN_FRAC_W];
    assign starget_val = sat_s32(66'(prod_hi));
    assign serr_val    = sat_s32(66'(starget_reg) - 66'(speed_reg));
    assign total_val   = TOTAL_W'(eterm_reg) + TOTAL_W'(prod_hi)
                       + TOTAL_W'(last_drive_reg[sel]);
    assign lim_t       = {{(TOTAL_W-31){1'b0}}, cfg.drive_limit};

    always_comb
    begin
        if (total_reg > lim_t)
        begin
            drive_val = 32'(lim_t);
        end
        else if (total_reg < -lim_t)
        begin
            drive_val = 32'(-lim_t);
        end
        else
        begin
            drive_val = total_reg[31:0];
        end
    end

    // left motor is mirrored
    assign center_q = {16'd0, cfg.pwm_center, {FRAC_W{1'b0}}};
    assign pq       = sel ? center_q + PQ_W'(prod_reg) : center_q - PQ_W'(prod_reg);
    assign pq_hi    = pq[PQ_W-1:FRAC_W];

    always_comb
    begin
        if (pq_hi < 0)
        begin
            pwm_val = '0;
        end
        else if (pq_hi > PQH_W'(2**PWM_W - 1))
        begin
            pwm_val = '1;
        end
        else
        begin
            pwm_val = pq_hi[PWM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg[0]        <= '0;
            sum_reg[1]        <= '0;
            last_serr_reg[0]  <= '0;
            last_serr_reg[1]  <= '0;
            last_drive_reg[0] <= '0;
            last_drive_reg[1] <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_LOAD:
                begin
                    if (tick.clear_position)
                    begin
                        sum_reg[0] <= '0;
                        sum_reg[1] <= '0;
                    end
                end
                OP_ACC:
                begin
                    sum_reg[sel] <= sum_sat;
                end
                OP_MUL_SLOPE:
                begin
                    last_serr_reg[sel]  <= serr_reg;
                    last_drive_reg[sel] <= drive_reg;
                end
                OP_PUBLISH:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        case (cmd.op)
            OP_LOAD:
            begin
                item_reg <= tick;
            end
            OP_ANGLE:
            begin
                perr_reg <= perr_val;
                if (sel)
                begin
                    res_reg.right_angle <= angle_val;
                end
                else
                begin
                    res_reg.left_angle <= angle_val;
                end
            end
            OP_SPEED:
            begin
                speed_reg <= speed_val;
            end
            OP_MUL_PGAIN:
            begin
                if (sel)
                begin
                    res_reg.right_enable <= enable_val;
                end
                else
                begin
                    res_reg.left_enable <= enable_val;
                end
            end
            OP_STARGET:
            begin
                starget_reg <= starget_val;
            end
            OP_SERR:
            begin
                serr_reg <= serr_val;
            end
            OP_MUL_PEGAIN:
            begin
                eterm_reg <= prod_hi;
            end
            OP_SUM:
            begin
                total_reg <= total_val;
            end
            OP_CLAMP:
            begin
                drive_reg <= drive_val;
            end
            OP_MUL_SLOPE:
            begin
                if (sel)
                begin
                    res_reg.right_drive <= drive_reg;
                end
                else
                begin
                    res_reg.left_drive <= drive_reg;
                end
            end
            OP_PWM:
            begin
                if (sel)
                begin
                    res_reg.right_pwm <= pwm_val;
                end
                else
                begin
                    res_reg.left_pwm <= pwm_val;
                end
            end
            OP_PUBLISH:
            begin
                out_reg <= res_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.div_busy = div_busy;
    assign status.out_full = out_valid_reg;
    assign result_valid    = out_valid_reg;
    assign result          = out_reg;

    assign lim33   = {2'b00, cfg.drive_limit};
    assign drive33 = 33'(drive_reg);

`ifndef NO_ASSERTIONS
    a_drive_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_CLAMP) |=> (drive33 <= $past(lim33)) && (drive33 >= -$past(lim33)))
        else $error("drive outside its limit");
`endif

endmodule

`default_nettype wire

// ----- src/dcps_controller.sv -----
`default_nettype none

module dcps_controller (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              tick_valid,
    input  wire dcps_pkg::status_t status,
    output dcps_pkg::cmd_t         cmd,
    output logic                   busy
);
    import dcps_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV_ANGLE,
        ST_WAIT_ANGLE,
        ST_ANGLE,
        ST_DIV_SPEED,
        ST_WAIT_SPEED,
        ST_SPEED,
        ST_MUL_PGAIN,
        ST_STARGET,
        ST_SERR,
        ST_MUL_EGAIN,
        ST_MUL_PEGAIN,
        ST_SUM,
        ST_CLAMP,
        ST_MUL_SLOPE,
        ST_PWM,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   motor_reg, motor_next;

    always_comb
    begin
        state_next = state_reg;
        motor_next = motor_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_valid)
                begin
                    state_next = ST_ACC;
                    motor_next = 1'b0;
                end
            end
            ST_ACC:        state_next = ST_DIV_ANGLE;
            ST_DIV_ANGLE:  state_next = ST_WAIT_ANGLE;
            ST_WAIT_ANGLE:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_ANGLE;
                end
            end
            ST_ANGLE:      state_next = ST_DIV_SPEED;
            ST_DIV_SPEED:  state_next = ST_WAIT_SPEED;
            ST_WAIT_SPEED:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_SPEED;
                end
            end
            ST_SPEED:      state_next = ST_MUL_PGAIN;
            ST_MUL_PGAIN:  state_next = ST_STARGET;
            ST_STARGET:    state_next = ST_SERR;
            ST_SERR:       state_next = ST_MUL_EGAIN;
            ST_MUL_EGAIN:  state_next = ST_MUL_PEGAIN;
            ST_MUL_PEGAIN: state_next = ST_SUM;
            ST_SUM:        state_next = ST_CLAMP;
            ST_CLAMP:      state_next = ST_MUL_SLOPE;
            ST_MUL_SLOPE:  state_next = ST_PWM;
            ST_PWM:
            begin
                if (motor_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_ACC;
                    motor_next = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.motor = motor_reg;
        case (state_reg)
            ST_IDLE:       cmd.op = tick_valid ? OP_LOAD : OP_NOP;
            ST_ACC:        cmd.op = OP_ACC;
            ST_DIV_ANGLE:  cmd.op = OP_DIV_ANGLE;
            ST_ANGLE:      cmd.op = OP_ANGLE;
            ST_DIV_SPEED:  cmd.op = OP_DIV_SPEED;
            ST_SPEED:      cmd.op = OP_SPEED;
            ST_MUL_PGAIN:  cmd.op = OP_MUL_PGAIN;
            ST_STARGET:    cmd.op = OP_STARGET;
            ST_SERR:       cmd.op = OP_SERR;
            ST_MUL_EGAIN:  cmd.op = OP_MUL_EGAIN;
            ST_MUL_PEGAIN: cmd.op = OP_MUL_PEGAIN;
            ST_SUM:        cmd.op = OP_SUM;
            ST_CLAMP:      cmd.op = OP_CLAMP;
            ST_MUL_SLOPE:  cmd.op = OP_MUL_SLOPE;
            ST_PWM:        cmd.op = OP_PWM;
            ST_FINISH:     cmd.op = status.out_full ? OP_NOP : OP_PUBLISH;
            default:       cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            motor_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            motor_reg <= motor_next;
        end
    end

    assign busy      = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// ----- src/dual_cascade_position_servo.sv -----
`default_nettype none

// channel  dir  handshake                    payload
// tick     in   tick_valid / tick_stall      dcps_pkg::tick_t
// result   out  result_valid / result_stall  dcps_pkg::result_t
// cfg      in   cfg_valid / cfg_ready        cfg_index, cfg_data
//
// a tick is accepted only while idle; tick_stall stays high from acceptance until its result is published
// each tick is worked through the shared divider (four divisions: angle and speed for each motor)
// and the single shared multiplier that serves both motors in turn
// reset loads the register defaults and clears the count sums and controller memory
// a finished result waits in its own register while the next tick is accepted;
// a tick that completes while that register is still full waits for it

module dual_cascade_position_servo #(
    parameter int COUNTS_PER_RADIAN = dcps_pkg::COUNTS_PER_RADIAN_DEF,
    parameter int SPEED_DIVISOR     = dcps_pkg::SPEED_DIVISOR_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            tick_valid,
    output logic                                 tick_stall,
    input  wire dcps_pkg::tick_t                 tick,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output dcps_pkg::result_t                    result,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [dcps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dcps_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dcps_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;
    logic    busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_POSITION_TOLERANCE:  cfg_reg.position_tolerance  <= cfg_data[30:0];
                CFG_DRIVE_LIMIT:         cfg_reg.drive_limit         <= cfg_data[30:0];
                CFG_POSITION_GAIN:       cfg_reg.position_gain       <= cfg_data;
                CFG_ERROR_GAIN:          cfg_reg.error_gain          <= cfg_data;
                CFG_PREVIOUS_ERROR_GAIN: cfg_reg.previous_error_gain <= cfg_data;
                CFG_PWM_CENTER:          cfg_reg.pwm_center          <= cfg_data[13:0];
                CFG_PWM_SLOPE:           cfg_reg.pwm_slope           <= cfg_data[11:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready  = 1'b1;
    assign tick_stall = busy;

    dcps_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .status     (status),
        .cmd        (cmd),
        .busy       (busy)
    );

    dcps_datapath #(
        .COUNTS_PER_RADIAN (COUNTS_PER_RADIAN),
        .SPEED_DIVISOR     (SPEED_DIVISOR)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .tick         (tick),
        .cfg          (cfg_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && !tick_stall) |=> tick_stall)
        else $error("tick accepted without going busy");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(tick_stall))
        else $error("result appeared without a tick in work");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/dcps_servo_checker.sv -----
`timescale 1ns / 1ps

module dcps_servo_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             tick_valid,
    input  wire logic                             tick_stall,
    input  wire dcps_pkg::tick_t                  tick,
    input  wire logic                             result_valid,
    input  wire logic                             result_stall,
    input  wire dcps_pkg::result_t                result,
    input  wire logic                             cfg_valid,
    input  wire logic                             cfg_ready,
    input  wire logic [dcps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dcps_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                    mismatches,
    output int                                    outstanding,
    output int                                    results_checked,
    output int                                    inside_band
);

    import dcps_pkg::*;

    localparam int     LEFT       = 0;
    localparam int     RIGHT      = 1;
    localparam longint SUM_HI     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO     = -SUM_HI - 1;
    localparam longint S32_HI     = 64'sd2147483647;
    localparam longint S32_LO     = -64'sd2147483648;
    localparam longint PWM_HI     = (64'sd1 <<< PWM_W) - 1;

    cfg_t    regs;
    longint  count_sum [2];
    longint  last_speed_err [2];
    longint  last_drive [2];
    result_t servo_outputs_due [$];
    int      errors;
    int      checked;
    int      quiet;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    // one motor of the cascade: position loop, speed loop, incremental pi, pwm map
    function automatic void servo_axis(
        input  int                 side,
        input  longint             delta,
        input  longint             target,
        input  bit                 mirror,
        output logic [PWM_W-1:0]   pwm,
        output logic               enable,
        output logic signed [31:0] drive_out,
        output logic signed [31:0] angle_out
    );
        longint angle;
        longint speed;
        longint pos_err;
        longint speed_target;
        longint speed_err;
        longint drive;
        longint lim;
        longint tol;
        longint slope_drive;
        longint compare;
        count_sum[side] = clip(count_sum[side] + delta, SUM_LO, SUM_HI);
        angle = clip((count_sum[side] * 65536) / COUNTS_PER_RADIAN_DEF, S32_LO, S32_HI);
        speed = (delta * 65536) / SPEED_DIVISOR_DEF;
        pos_err = clip((target <<< FRAC_W) - angle, S32_LO, S32_HI);
        speed_target = clip((longint'({32'd0, regs.position_gain}) * pos_err) >>> GAIN_FRAC_W,
                            S32_LO, S32_HI);
        speed_err = clip(speed_target - speed, S32_LO, S32_HI);
        drive = ((longint'({32'd0, regs.error_gain}) * speed_err) >>> GAIN_FRAC_W)
              + ((longint'({32'd0, regs.previous_error_gain}) * last_speed_err[side])
                 >>> GAIN_FRAC_W)
              + last_drive[side];
        lim = longint'({33'd0, regs.drive_limit});
        drive = clip(drive, -lim, lim);
        slope_drive = longint'({52'd0, regs.pwm_slope}) * drive;
        compare = (longint'({50'd0, regs.pwm_center}) <<< FRAC_W)
                + (mirror ? -slope_drive : slope_drive);
        tol = longint'({33'd0, regs.position_tolerance});
        pwm = PWM_W'(clip(compare >>> FRAC_W, 0, PWM_HI));
        enable = (pos_err < tol && pos_err > -tol) ? 1'b0 : 1'b1;
        drive_out = drive[31:0];
        angle_out = angle[31:0];
        last_speed_err[side] = speed_err;
        last_drive[side] = drive;
    endfunction

    function automatic result_t servo_outputs(input tick_t t);
        result_t            r;
        logic [PWM_W-1:0]   pwm;
        logic               enable;
        logic signed [31:0] drive;
        logic signed [31:0] angle;
        if (t.clear_position)
        begin
            count_sum[LEFT] = 0;
            count_sum[RIGHT] = 0;
        end
        servo_axis(LEFT, longint'(t.left_count_delta), longint'(t.left_target), 1'b1,
                   pwm, enable, drive, angle);
        r.left_pwm = pwm;
        r.left_enable = enable;
        r.left_drive = drive;
        r.left_angle = angle;
        servo_axis(RIGHT, longint'(t.right_count_delta), longint'(t.right_target), 1'b0,
                   pwm, enable, drive, angle);
        r.right_pwm = pwm;
        r.right_enable = enable;
        r.right_drive = drive;
        r.right_angle = angle;
        return r;
    endfunction

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got)
        begin
            $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            regs = CFG_RESET;
            for (int i = LEFT; i <= RIGHT; i++)
            begin
                count_sum[i] = 0;
                last_speed_err[i] = 0;
                last_drive[i] = 0;
            end
            servo_outputs_due.delete();
            errors = 0;
            checked = 0;
            quiet = 0;
            mismatches <= 0;
            outstanding <= 0;
            results_checked <= 0;
            inside_band <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_POSITION_TOLERANCE:  regs.position_tolerance = cfg_data[30:0];
                    CFG_DRIVE_LIMIT:         regs.drive_limit = cfg_data[30:0];
                    CFG_POSITION_GAIN:       regs.position_gain = cfg_data;
                    CFG_ERROR_GAIN:          regs.error_gain = cfg_data;
                    CFG_PREVIOUS_ERROR_GAIN: regs.previous_error_gain = cfg_data;
                    CFG_PWM_CENTER:          regs.pwm_center = cfg_data[PWM_W-1:0];
                    CFG_PWM_SLOPE:           regs.pwm_slope = cfg_data[11:0];
                    default: ;
                endcase
            end
            if (result_valid && !result_stall)
            begin
                if (servo_outputs_due.size() == 0)
                begin
                    $display("%0t result transaction with nothing expected", $time);
                    errors++;
                end
                else
                begin
                    want = servo_outputs_due.pop_front();
                    compare_field("left_pwm", want.left_pwm, result.left_pwm);
                    compare_field("right_pwm", want.right_pwm, result.right_pwm);
                    compare_field("left_enable", want.left_enable, result.left_enable);
                    compare_field("right_enable", want.right_enable, result.right_enable);
                    compare_field("left_drive", want.left_drive, result.left_drive);
                    compare_field("right_drive", want.right_drive, result.right_drive);
                    compare_field("left_angle", want.left_angle, result.left_angle);
                    compare_field("right_angle", want.right_angle, result.right_angle);
                    checked++;
                    if (!want.left_enable || !want.right_enable)
                    begin
                        quiet++;
                    end
                end
            end
            if (tick_valid && !tick_stall)
            begin
                servo_outputs_due.push_back(servo_outputs(tick));
            end
            mismatches <= errors;
            outstanding <= servo_outputs_due.size();
            results_checked <= checked;
            inside_band <= quiet;
        end
    end

endmodule

// ----- tb/sv/tb_dual_cascade_position_servo.sv -----
`timescale 1ns / 1ps

module tb_dual_cascade_position_servo;

    import dcps_pkg::*;

    localparam int PHASES          = 7;
    localparam int TICKS_PER_PHASE = 155;
    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 80;
    localparam int BURST_TICKS     = 45;

    logic                   clk;
    logic                   rst_n;
    logic                   tick_valid;
    logic                   tick_stall;
    tick_t                  tick_in;
    logic                   result_valid;
    logic                   result_stall;
    result_t                result_out;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int     mismatches;
    int     outstanding;
    int     results_checked;
    int     inside_band;
    int     idle_cycles;
    int     ticks_sent;
    bit     gaps_on;
    bit     stall_on;
    int     burst_left;
    bit     burst_up;
    longint aim_sum [2];

    dual_cascade_position_servo i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    dcps_servo_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .tick_valid      (tick_valid),
        .tick_stall      (tick_stall),
        .tick            (tick_in),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .inside_band     (inside_band)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if ((tick_valid && !tick_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("tb_dual_cascade_position_servo: done, errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side back-pressure, held for a random number of edges per transaction
    initial
    begin
        int hold;
        int count;
        result_stall = 1'b0;
        stall_on = 1'b0;
        count = 0;
        @(posedge rst_n);
        forever
        begin
            if (count % 30 == 0)
            begin
                stall_on = ($urandom_range(0, 2) != 0);
            end
            count++;
            hold = stall_on ? int'($urandom_range(0, 4)) : 0;
            result_stall <= (hold != 0);
            @(posedge clk);
            while (!result_valid)
            begin
                @(posedge clk);
            end
            if (hold != 0)
            begin
                repeat (hold - 1) @(posedge clk);
                result_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    function automatic longint clip16(input longint v);
        if (v > 32767)
        begin
            return 32767;
        end
        if (v < -32768)
        begin
            return -32768;
        end
        return v;
    endfunction

    function automatic tick_t mk(input int ld, input int rd, input int lt, input int rt,
                                 input bit clr);
        tick_t t;
        t.left_count_delta = ld[15:0];
        t.right_count_delta = rd[15:0];
        t.left_target = lt[15:0];
        t.right_target = rt[15:0];
        t.clear_position = clr;
        return t;
    endfunction

    // ticks that steer the position onto the target most often, then small moves, then noise
    function automatic void axis_stimulus(input longint sum, input int pick,
                                          output logic [15:0] delta,
                                          output logic [15:0] target);
        int     jitter;
        int     offset;
        longint goal;
        longint step;
        jitter = int'($urandom_range(0, 4)) - 2;
        offset = int'($urandom_range(0, 6)) - 3;
        goal = clip16(sum / COUNTS_PER_RADIAN_DEF + jitter);
        if (pick < 40)
        begin
            step = goal * COUNTS_PER_RADIAN_DEF + offset - sum;
            if (step > 32767 || step < -32768)
            begin
                step = int'($urandom_range(0, 600)) - 300;
            end
        end
        else if (pick < 75)
        begin
            step = int'($urandom_range(0, 600)) - 300;
        end
        else
        begin
            step = $urandom_range(0, 65535);
            goal = $urandom_range(0, 65535);
        end
        delta = step[15:0];
        target = goal[15:0];
    endfunction

    function automatic tick_t random_tick();
        tick_t       t;
        int          pick;
        logic [15:0] delta;
        logic [15:0] target;
        t.clear_position = ($urandom_range(0, 11) == 0);
        if (burst_left == 0 && $urandom_range(0, 199) == 0)
        begin
            burst_left = BURST_TICKS;
            burst_up = ($urandom_range(0, 1) != 0);
        end
        if (burst_left != 0)
        begin
            burst_left--;
            t.clear_position = 1'b0;
            t.left_count_delta = burst_up ? 16'sh7FFF : 16'sh8000;
            t.right_count_delta = burst_up ? 16'sh8000 : 16'sh7FFF;
            t.left_target = 16'($urandom_range(0, 65535));
            t.right_target = 16'($urandom_range(0, 65535));
            return t;
        end
        pick = $urandom_range(0, 99);
        axis_stimulus(t.clear_position ? 0 : aim_sum[0], pick, delta, target);
        t.left_count_delta = delta;
        t.left_target = target;
        pick = $urandom_range(0, 99);
        axis_stimulus(t.clear_position ? 0 : aim_sum[1], pick, delta, target);
        t.right_count_delta = delta;
        t.right_target = target;
        return t;
    endfunction

    task automatic issue(input tick_t t);
        int gap;
        if (ticks_sent % 40 == 0)
        begin
            gaps_on = ($urandom_range(0, 2) != 0);
        end
        if (t.clear_position)
        begin
            aim_sum[0] = 0;
            aim_sum[1] = 0;
        end
        aim_sum[0] += longint'(t.left_count_delta);
        aim_sum[1] += longint'(t.right_count_delta);
        gap = gaps_on ? int'($urandom_range(0, 4)) : 0;
        if (gap != 0)
        begin
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick_in <= t;
        @(posedge clk);
        while (tick_stall)
        begin
            @(posedge clk);
        end
        ticks_sent++;
    endtask

    task automatic settle();
        tick_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] setting [CFG_PWM_SLOPE+1];
        tick_valid = 1'b0;
        tick_in = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_cycles = 0;
        ticks_sent = 0;
        gaps_on = 1'b0;
        burst_left = 0;
        burst_up = 1'b0;
        aim_sum[0] = 0;
        aim_sum[1] = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(mk(0, 0, 0, 0, 1'b0));
        issue(mk(32767, 32767, 0, 0, 1'b0));
        issue(mk(-32768, -32768, 0, 0, 1'b0));
        issue(mk(0, 0, 32767, -32768, 1'b0));
        issue(mk(0, 0, -32768, 32767, 1'b0));
        issue(mk(1, -1, 0, 0, 1'b1));
        // lands exactly on one radian
        issue(mk(41, 41, 1, 1, 1'b1));
        issue(mk(0, 0, 1, 1, 1'b0));
        issue(mk(-32768, 32767, -32768, 32767, 1'b0));
        issue(mk(0, 0, 0, 0, 1'b1));
        issue(mk(-41, -41, -1, -1, 1'b1));
        issue(mk(2, 3, -1, -1, 1'b0));
        issue(mk(-3, -2, -1, -1, 1'b0));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase != 0)
            begin
                settle();
                setting[CFG_POSITION_TOLERANCE] = CFG_RESET.position_tolerance;
                setting[CFG_DRIVE_LIMIT] = CFG_RESET.drive_limit;
                setting[CFG_POSITION_GAIN] = CFG_RESET.position_gain;
                setting[CFG_ERROR_GAIN] = CFG_RESET.error_gain;
                setting[CFG_PREVIOUS_ERROR_GAIN] = CFG_RESET.previous_error_gain;
                setting[CFG_PWM_CENTER] = CFG_RESET.pwm_center;
                setting[CFG_PWM_SLOPE] = CFG_RESET.pwm_slope;
                case (phase)
                    1:
                    begin
                        for (int i = 0; i <= CFG_PWM_SLOPE; i++)
                        begin
                            setting[i] = '1;
                        end
                    end
                    2:
                    begin
                        for (int i = 0; i <= CFG_PWM_SLOPE; i++)
                        begin
                            setting[i] = '0;
                        end
                    end
                    3:
                    begin
                        for (int i = 0; i <= CFG_PWM_SLOPE; i++)
                        begin
                            setting[i] = $urandom;
                        end
                    end
                    4:
                    begin
                        setting[CFG_POSITION_TOLERANCE] = '0;
                        setting[CFG_PWM_CENTER] = '0;
                        setting[CFG_PWM_SLOPE] = 4095;
                    end
                    5:
                    begin
                        setting[CFG_POSITION_TOLERANCE] = $urandom_range(0, 20000);
                        setting[CFG_DRIVE_LIMIT] = $urandom_range(0, 2000000);
                        setting[CFG_POSITION_GAIN] = $urandom_range(0, 50000000);
                        setting[CFG_ERROR_GAIN] = $urandom_range(0, 200000);
                        setting[CFG_PREVIOUS_ERROR_GAIN] = $urandom_range(0, 200000);
                        setting[CFG_PWM_CENTER] = $urandom_range(0, 16383);
                        setting[CFG_PWM_SLOPE] = $urandom_range(0, 4095);
                    end
                    default:
                    begin
                        setting[CFG_DRIVE_LIMIT] = 1;
                        setting[CFG_PWM_CENTER] = 16383;
                        setting[CFG_PWM_SLOPE] = 4095;
                    end
                endcase
                for (int i = 0; i <= CFG_PWM_SLOPE; i++)
                begin
                    write_reg(cfg_index_t'(i), setting[i]);
                end
                cfg_valid <= 1'b0;
            end
            repeat (TICKS_PER_PHASE) issue(random_tick());
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d control ticks sent across %0d register settings, %0d results compared",
                 ticks_sent, PHASES, results_checked);
        $display("%0d results had at least one motor held inside its position tolerance",
                 inside_band);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("tb_dual_cascade_position_servo: done, clean");
        end
        else
        begin
            $display("tb_dual_cascade_position_servo: done, errors");
        end
        $finish;
    end

endmodule
